@@ rtl/core/page_refcount_region_tracker_top_macros.svh @@
// Assertion macros for the page refcount region tracker RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PAGE_REFCOUNT_REGION_TRACKER_TOP_MACROS_SVH
`define PAGE_REFCOUNT_REGION_TRACKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/prt_pkg.sv @@
// Shared types and fixed constants for the page refcount region tracker.
// No dependencies.
package prt_pkg;

  localparam int ADDR_W  = 24;
  localparam int BYTES_W = 19;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_RANGE     = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_CLOSE,
    ST_FINAL
  } back_state_t;

  // Result item as held in the result queue.
  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  start;
    logic [BYTES_W-1:0] bytes;
    logic               cached;
    err_t               err;
    logic               last;
  } res_t;

  // Back-end requests towards the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_req_t;

endpackage

@@ rtl/core/prt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module prt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/prt_fifo.sv @@
// Small show-ahead FIFO built from registers.
// No dependencies.
module prt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign level   = cnt_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/core/prt_front.sv @@
// Front end: registers a request, works out its page span, range-checks it
// and queues a walk command. Depends on prt_pkg and prt_fifo.
module prt_front #(
  parameter int PAGE_BITS     = 12,
  parameter int PAGE_COUNT    = 4096,
  parameter int MAX_REQ_PAGES = 64,
  parameter int CMD_W         = 4 + $clog2(PAGE_COUNT) + $clog2(MAX_REQ_PAGES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_func,
  input  logic [prt_pkg::ADDR_W-1:0]    in_start_address,
  input  logic [prt_pkg::BYTES_W-1:0]   in_byte_count,
  input  prt_pkg::back_req_t            back_req,
  output logic                          cmd_valid,
  output logic [CMD_W-1:0]              cmd_data
);
  import prt_pkg::*;

  localparam int PIDX_W = $clog2(PAGE_COUNT);
  localparam int NP_W   = $clog2(MAX_REQ_PAGES + 1);
  localparam int LB_W   = ADDR_W + 1;
  localparam int APG_W  = ADDR_W - PAGE_BITS;
  localparam int LPG_W  = LB_W - PAGE_BITS;

  logic              a_valid_r, a_valid_nxt;
  logic              a_dec_r;
  logic              a_zero_r;
  logic [APG_W-1:0]  a_first_r;
  logic [LPG_W-1:0]  a_lastpg_r;
  logic [LB_W-1:0]   last_byte;
  logic              accept;
  logic              cmdq_push, cmdq_full, cmdq_empty;
  logic [31:0]       span;
  logic              bad_end, bad_span, no_walk;
  err_t              cmd_err;
  logic [CMD_W-1:0]  cmd_wdata;

  assign accept    = in_push && !in_full;
  assign in_full   = back_req.clearing || (a_valid_r && cmdq_full);
  assign last_byte = LB_W'(in_start_address) + LB_W'(in_byte_count) - LB_W'(1);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (cmdq_push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_dec_r    <= in_func;
      a_zero_r   <= (in_byte_count == '0);
      a_first_r  <= in_start_address[ADDR_W-1:PAGE_BITS];
      a_lastpg_r <= last_byte[LB_W-1:PAGE_BITS];
    end
  end

  // Classify: zero length and rejected ranges become terminator-only commands.
  assign span     = 32'(a_lastpg_r) - 32'(a_first_r);
  assign bad_end  = 32'(a_lastpg_r) >= 32'(PAGE_COUNT);
  assign bad_span = span >= 32'(MAX_REQ_PAGES);
  assign no_walk  = a_zero_r || bad_end || bad_span;
  assign cmd_err  = (!a_zero_r && (bad_end || bad_span)) ? ERR_RANGE : ERR_OK;

  assign cmd_wdata = {a_dec_r, no_walk, cmd_err, PIDX_W'(a_first_r),
                      NP_W'(span + 32'd1)};
  assign cmdq_push = a_valid_r && !cmdq_full;

  prt_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmdq_push),
    .wdata (cmd_wdata),
    .pop   (back_req.pop),
    .rdata (cmd_data),
    .empty (cmdq_empty),
    .full  (cmdq_full),
    .level ()
  );

  assign cmd_valid = !cmdq_empty;

endmodule

@@ rtl/core/prt_back.sv @@
// Back end: clears the count table after reset, walks each command's pages
// with a read-modify-write pipeline and queues region results.
// Depends on prt_pkg, prt_ram, prt_fifo and the assertion macro header.
`include "page_refcount_region_tracker_top_macros.svh"

module prt_back #(
  parameter int PAGE_BITS     = 12,
  parameter int PAGE_COUNT    = 4096,
  parameter int MAX_REQ_PAGES = 64,
  parameter int CMD_W         = 4 + $clog2(PAGE_COUNT) + $clog2(MAX_REQ_PAGES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  logic [CMD_W-1:0]    cmd_data,
  output prt_pkg::back_req_t  back_req,
  input  logic                out_pop,
  output logic                out_empty,
  output prt_pkg::res_t       out_res
);
  import prt_pkg::*;

  localparam int PIDX_W = $clog2(PAGE_COUNT);
  localparam int NP_W   = $clog2(MAX_REQ_PAGES + 1);
  localparam int RES_W  = $bits(res_t);
  localparam int RQ_D   = 4;
  localparam int RQ_CW  = $clog2(RQ_D + 1);

  back_state_t       state_r, state_nxt;
  logic [PIDX_W-1:0] clr_r, clr_nxt;
  logic              dec_r, dec_nxt;
  err_t              err_r, err_nxt;
  logic [PIDX_W-1:0] cur_r, cur_nxt;
  logic [NP_W-1:0]   rem_r, rem_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [PIDX_W-1:0] s1_page_r, s1_page_nxt;
  logic              run_open_r, run_open_nxt;
  logic [PIDX_W-1:0] run_start_r, run_start_nxt;
  logic [NP_W-1:0]   run_len_r, run_len_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [PIDX_W-1:0] pend_start_r, pend_start_nxt;
  logic [NP_W-1:0]   pend_len_r, pend_len_nxt;
  logic              pend_cached_r, pend_cached_nxt;

  logic              ram_we, ram_re;
  logic [PIDX_W-1:0] ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;

  logic              res_push, res_full;
  logic [RQ_CW-1:0]  res_level;
  res_t              res_wdata, pend_res;
  logic [RES_W-1:0]  res_rdata;

  logic              cmd_dec, cmd_nowalk;
  err_t              cmd_err;
  logic [PIDX_W-1:0] cmd_first;
  logic [NP_W-1:0]   cmd_npages;

  logic              flagged, hit, issue, emit_ok;
  logic [COUNT_W-1:0] new_cnt;

  assign cmd_dec    = cmd_data[CMD_W-1];
  assign cmd_nowalk = cmd_data[CMD_W-2];
  assign cmd_err    = err_t'(cmd_data[CMD_W-3:CMD_W-4]);
  assign cmd_first  = cmd_data[NP_W+PIDX_W-1:NP_W];
  assign cmd_npages = cmd_data[NP_W-1:0];

  // Counter update for the page whose read data is back this cycle.
  assign flagged = dec_r ? (ram_rdata == '0) : (ram_rdata == COUNT_MAX);
  assign new_cnt = dec_r ? ram_rdata - COUNT_W'(1) : ram_rdata + COUNT_W'(1);
  assign hit     = !flagged && (dec_r ? (new_cnt == '0) : (new_cnt == COUNT_W'(1)));

  // Leave room for the push of the page already in flight.
  assign issue   = (rem_r != '0) && (res_level <= RQ_CW'(RQ_D - 2));
  assign emit_ok = !(pend_valid_r && res_full);

  always_comb begin
    pend_res        = '0;
    pend_res.valid  = 1'b1;
    pend_res.start  = ADDR_W'(32'(pend_start_r) << PAGE_BITS);
    pend_res.bytes  = BYTES_W'(32'(pend_len_r) << PAGE_BITS);
    pend_res.cached = pend_cached_r;
    pend_res.err    = ERR_OK;
    pend_res.last   = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == PIDX_W'(PAGE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = cmd_nowalk ? ST_FINAL : ST_WALK;
        end
      end
      ST_WALK: begin
        if (rem_r == '0 && !s1_valid_r) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (!run_open_r || emit_ok) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt         = clr_r;
    dec_nxt         = dec_r;
    err_nxt         = err_r;
    cur_nxt         = cur_r;
    rem_nxt         = rem_r;
    s1_valid_nxt    = 1'b0;
    s1_page_nxt     = s1_page_r;
    run_open_nxt    = run_open_r;
    run_start_nxt   = run_start_r;
    run_len_nxt     = run_len_r;
    pend_valid_nxt  = pend_valid_r;
    pend_start_nxt  = pend_start_r;
    pend_len_nxt    = pend_len_r;
    pend_cached_nxt = pend_cached_r;
    ram_we          = 1'b0;
    ram_waddr       = s1_page_r;
    ram_wdata       = new_cnt;
    ram_re          = 1'b0;
    ram_raddr       = cur_r;
    res_push        = 1'b0;
    res_wdata       = pend_res;
    back_req.pop      = 1'b0;
    back_req.clearing = (state_r == ST_CLEAR);

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + PIDX_W'(1);
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          back_req.pop   = 1'b1;
          dec_nxt        = cmd_dec;
          err_nxt        = cmd_err;
          cur_nxt        = cmd_first;
          rem_nxt        = cmd_npages;
          run_open_nxt   = 1'b0;
          pend_valid_nxt = 1'b0;
        end
      end
      ST_WALK: begin
        if (issue) begin
          ram_re       = 1'b1;
          s1_valid_nxt = 1'b1;
          s1_page_nxt  = cur_r;
          cur_nxt      = cur_r + PIDX_W'(1);
          rem_nxt      = rem_r - NP_W'(1);
        end
        if (s1_valid_r) begin
          ram_we = !flagged;
          if (flagged) begin
            err_nxt = dec_r ? ERR_UNDERFLOW : ERR_OVERFLOW;
          end
          if (hit) begin
            if (run_open_r) begin
              run_len_nxt = run_len_r + NP_W'(1);
            end else begin
              run_open_nxt  = 1'b1;
              run_start_nxt = s1_page_r;
              run_len_nxt   = NP_W'(1);
            end
          end else if (run_open_r) begin
            // Run broken: release the held region, hold the closed run.
            res_push        = pend_valid_r;
            pend_valid_nxt  = 1'b1;
            pend_start_nxt  = run_start_r;
            pend_len_nxt    = run_len_r;
            pend_cached_nxt = !dec_r;
            run_open_nxt    = 1'b0;
          end
        end
      end
      ST_CLOSE: begin
        if (run_open_r && emit_ok) begin
          res_push        = pend_valid_r;
          pend_valid_nxt  = 1'b1;
          pend_start_nxt  = run_start_r;
          pend_len_nxt    = run_len_r;
          pend_cached_nxt = !dec_r;
          run_open_nxt    = 1'b0;
        end
      end
      ST_FINAL: begin
        if (!pend_valid_r) begin
          res_wdata = '0;
        end
        res_wdata.err  = err_r;
        res_wdata.last = 1'b1;
        res_push       = !res_full;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      s1_valid_r   <= 1'b0;
      run_open_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      rem_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      s1_valid_r   <= s1_valid_nxt;
      run_open_r   <= run_open_nxt;
      pend_valid_r <= pend_valid_nxt;
      rem_r        <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dec_r         <= dec_nxt;
    err_r         <= err_nxt;
    cur_r         <= cur_nxt;
    s1_page_r     <= s1_page_nxt;
    run_start_r   <= run_start_nxt;
    run_len_r     <= run_len_nxt;
    pend_start_r  <= pend_start_nxt;
    pend_len_r    <= pend_len_nxt;
    pend_cached_r <= pend_cached_nxt;
  end

  prt_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (PAGE_COUNT)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  prt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RQ_D)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty),
    .full  (res_full),
    .level (res_level)
  );

  assign out_res = res_t'(res_rdata);

  `PRT_ASSERT_SAME(a_no_push_full, clk, rst_n, res_push, !res_full, "result pushed while queue full")
  `PRT_ASSERT_SAME(a_rmw_addr, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "read and write hit one page")
  `PRT_ASSERT_SAME(a_pipe_in_walk, clk, rst_n, s1_valid_r, state_r == ST_WALK, "page in flight outside walk")
  `PRT_ASSERT_NEXT(a_clear_exit, clk, rst_n, state_r == ST_CLEAR, state_r == ST_CLEAR || state_r == ST_IDLE, "clear pass left early")
  `PRT_ASSERT_SAME(a_run_scope, clk, rst_n, run_open_r, state_r == ST_WALK || state_r == ST_CLOSE, "open run outside walk")

endmodule

@@ rtl/core/page_refcount_region_tracker_top.sv @@
// Page reference-count region tracker, top level.
// Instantiates prt_front and prt_back; types and constants come from prt_pkg.
//
// The block keeps a 16-bit reference count per page (PAGE_COUNT pages of
// 2^PAGE_BITS bytes) and takes requests through a queue-like port: push and
// full on the request side, empty and pop on the result side. Each request
// names a byte range and a direction (in_func 0 increments, 1 decrements) and
// gives one or more results: contiguous regions that became cached (count went
// to one) or uncached (count went to zero), the final one flagged last and
// carrying the sticky error code. Zero-length requests and rejected ranges
// give a single empty result. After reset the count table is cleared, one
// page a cycle, during which in_full stays high. The walk engine handles one
// page a cycle while the result queue has room, using the separate read and
// write ports of the count memory for the read-modify-write, after the
// command pop and before a pipeline drain and two closing steps; a result
// queue near full stalls the walk. The front end registers each request and
// passes it through the command queue, and can hold three further requests,
// and up to four results wait in the result queue.
module page_refcount_region_tracker_top #(
  parameter int PAGE_BITS     = 12,
  parameter int PAGE_COUNT    = 4096,
  parameter int MAX_REQ_PAGES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_func,
  input  logic [prt_pkg::ADDR_W-1:0]  in_start_address,
  input  logic [prt_pkg::BYTES_W-1:0] in_byte_count,
  // result channel
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_region_valid,
  output logic [prt_pkg::ADDR_W-1:0]  out_region_start,
  output logic [prt_pkg::BYTES_W-1:0] out_region_bytes,
  output logic                        out_now_cached,
  output logic [1:0]                  out_error_code,
  output logic                        out_last
);
  import prt_pkg::*;

  // Walk command: direction, no-walk flag, error, first page, page count.
  localparam int CMD_W = 4 + $clog2(PAGE_COUNT) + $clog2(MAX_REQ_PAGES + 1);

  logic             cmd_valid;
  logic [CMD_W-1:0] cmd_data;
  back_req_t        back_req;
  res_t             out_res;

  // Front: register the request, classify it, queue the command.
  prt_front #(
    .PAGE_BITS     (PAGE_BITS),
    .PAGE_COUNT    (PAGE_COUNT),
    .MAX_REQ_PAGES (MAX_REQ_PAGES),
    .CMD_W         (CMD_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_func          (in_func),
    .in_start_address (in_start_address),
    .in_byte_count    (in_byte_count),
    .back_req         (back_req),
    .cmd_valid        (cmd_valid),
    .cmd_data         (cmd_data)
  );

  // Back: clear the table, walk pages, merge runs, queue each result transfer.
  prt_back #(
    .PAGE_BITS     (PAGE_BITS),
    .PAGE_COUNT    (PAGE_COUNT),
    .MAX_REQ_PAGES (MAX_REQ_PAGES),
    .CMD_W         (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .back_req  (back_req),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (out_res)
  );

  assign out_region_valid = out_res.valid;
  assign out_region_start = out_res.start;
  assign out_region_bytes = out_res.bytes;
  assign out_now_cached   = out_res.cached;
  assign out_error_code   = out_res.err;
  assign out_last         = out_res.last;

endmodule

@@ tb/sv/page_refcount_region_tracker_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for page_refcount_region_tracker_top: a request driver and a result
// monitor around a page refcount predictor. Needs prt_pkg and the tracker RTL only.
module page_refcount_region_tracker_top_test;
  import prt_pkg::*;

  localparam int PAGE_BITS     = 12;
  localparam int PAGE_COUNT    = 4096;
  localparam int MAX_REQ_PAGES = 64;
  localparam int PAGE_BYTES    = 1 << PAGE_BITS;
  localparam int MAX_LEN       = MAX_REQ_PAGES * PAGE_BYTES;
  // The limit covers the slowest correct run: the clearing pass plus
  // every request at full span with the longest result stalls.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 200;
  localparam int REPORT_CAP    = 100;

  // One request as queued for the driver.
  typedef struct {
    bit              func;
    bit [ADDR_W-1:0]  addr;
    bit [BYTES_W-1:0] len;
    int              gap;
    bit              calm;   // no idling on either side for this request
    bit              drain;  // hold until every expected region has arrived
  } request_t;

  // One expected result, tagged with the idling mode of its request.
  typedef struct {
    res_t res;
    bit   calm;
  } region_due_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic                in_func = 1'b0;
  logic [ADDR_W-1:0]   in_start_address = '0;
  logic [BYTES_W-1:0]  in_byte_count = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic                out_region_valid;
  logic [ADDR_W-1:0]   out_region_start;
  logic [BYTES_W-1:0]  out_region_bytes;
  logic                out_now_cached;
  logic [1:0]          out_error_code;
  logic                out_last;

  request_t    request_q[$];
  region_due_t regions_due[$];
  logic [COUNT_W-1:0] page_refs [PAGE_COUNT];

  request_t    cur_req;
  bit          have_req = 1'b0;
  int          push_wait = 0;
  int          pop_hold = 0;
  region_due_t want;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  page_refcount_region_tracker_top #(
    .PAGE_BITS    (PAGE_BITS),
    .PAGE_COUNT   (PAGE_COUNT),
    .MAX_REQ_PAGES(MAX_REQ_PAGES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_start_address(in_start_address),
    .in_byte_count   (in_byte_count),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_region_valid(out_region_valid),
    .out_region_start(out_region_start),
    .out_region_bytes(out_region_bytes),
    .out_now_cached  (out_now_cached),
    .out_error_code  (out_error_code),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build one region result; error and last are filled in at the end of the walk.
  function automatic res_t region(int first_pg, int pages, bit cached);
    res_t r;
    r.valid  = 1'b1;
    r.start  = ADDR_W'(first_pg << PAGE_BITS);
    r.bytes  = BYTES_W'(pages << PAGE_BITS);
    r.cached = cached;
    r.err    = ERR_OK;
    r.last   = 1'b0;
    return r;
  endfunction

  // Walk the pages of one accepted request, update the counts and queue the
  // regions it should report.
  function automatic void walk_page_counts(bit dec, bit [ADDR_W-1:0] addr,
                                           bit [BYTES_W-1:0] len, bit calm);
    res_t   found[$];
    res_t   r;
    err_t   err = ERR_OK;
    longint last_byte;
    int     first_pg, end_pg;
    int     unc_start = 0, unc_pages = 0, cac_start = 0, cac_pages = 0;
    bit     flagged, zeroed, oned;
    if (len != 0) begin
      // Work wide here: a range may run past the top of the address space.
      last_byte = longint'(addr) + longint'(len) - 1;
      first_pg  = int'(addr >> PAGE_BITS);
      end_pg    = int'(last_byte >> PAGE_BITS) + 1;
      if (end_pg > PAGE_COUNT || end_pg - first_pg > MAX_REQ_PAGES) begin
        err = ERR_RANGE;
      end else begin
        for (int p = first_pg; p < end_pg; p++) begin
          flagged = 1'b0;
          if (dec) begin
            if (page_refs[p] == '0) begin
              flagged = 1'b1;
              err = ERR_UNDERFLOW;
            end else begin
              page_refs[p] = page_refs[p] - 1'b1;
            end
          end else begin
            if (page_refs[p] == COUNT_MAX) begin
              flagged = 1'b1;
              err = ERR_OVERFLOW;
            end else begin
              page_refs[p] = page_refs[p] + 1'b1;
            end
          end
          zeroed = !flagged && page_refs[p] == '0;
          oned   = !flagged && !dec && page_refs[p] == COUNT_W'(1);
          // A page that does not extend a run closes it.
          if (zeroed) begin
            if (unc_pages == 0) unc_start = p;
            unc_pages++;
          end else if (unc_pages > 0) begin
            found.push_back(region(unc_start, unc_pages, 1'b0));
            unc_pages = 0;
          end
          if (oned) begin
            if (cac_pages == 0) cac_start = p;
            cac_pages++;
          end else if (cac_pages > 0) begin
            found.push_back(region(cac_start, cac_pages, 1'b1));
            cac_pages = 0;
          end
        end
        if (unc_pages > 0) found.push_back(region(unc_start, unc_pages, 1'b0));
        if (cac_pages > 0) found.push_back(region(cac_start, cac_pages, 1'b1));
      end
    end
    if (found.size() == 0) begin
      r = '0;
      found.push_back(r);
    end
    r = found.pop_back();
    r.err  = err;
    r.last = 1'b1;
    found.push_back(r);
    foreach (found[i]) regions_due.push_back('{res: found[i], calm: calm});
  endfunction

  function automatic void queue_request(bit func, bit [ADDR_W-1:0] addr,
                                        bit [BYTES_W-1:0] len, bit calm, bit drain);
    request_t q;
    q.func  = func;
    q.addr  = addr;
    q.len   = len;
    q.gap   = calm ? 0 : $urandom_range(0, 5);
    q.calm  = calm;
    q.drain = drain;
    request_q.push_back(q);
  endfunction

  task automatic compare_field(string name, logic [ADDR_W-1:0] expv, logic [ADDR_W-1:0] act);
    if (act !== expv) begin
      mismatches++;
      // Stay quiet after the first few screens of reports.
      if (mismatches <= REPORT_CAP)
        $error("%s mismatch: expected %0h, actual %0h", name, expv, act);
    end
  endtask

  // Driver: present the head of request_q, predict each request on its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        walk_page_counts(cur_req.func, cur_req.addr, cur_req.len, cur_req.calm);
        have_req = 1'b0;
      end
      if (!have_req && request_q.size() > 0) begin
        cur_req   = request_q.pop_front();
        have_req  = 1'b1;
        push_wait = cur_req.gap;
      end
      if (have_req && cur_req.drain && regions_due.size() != 0) begin
        in_push <= 1'b0;                 // hold until the block has drained
      end else if (have_req && push_wait > 0) begin
        push_wait--;
        in_push <= 1'b0;
      end else begin
        in_push <= have_req;
      end
      if (have_req) begin
        in_func          <= cur_req.func;
        in_start_address <= cur_req.addr;
        in_byte_count    <= cur_req.len;
      end
    end
  end

  // Monitor: accept results with random stalls and check each against the
  // oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_hold = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (regions_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $error("result transfer with no region expected (start %0h)", out_region_start);
        end else begin
          want = regions_due.pop_front();
          compare_field("region_valid", want.res.valid, out_region_valid);
          compare_field("region_start", want.res.start, out_region_start);
          compare_field("region_bytes", want.res.bytes, out_region_bytes);
          compare_field("now_cached", want.res.cached, out_now_cached);
          compare_field("error_code", want.res.err, out_error_code);
          compare_field("last", want.res.last, out_last);
          pop_hold = want.calm ? 0 : $urandom_range(0, 5);
        end
      end
      if (pop_hold > 0) begin
        pop_hold--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    bit [ADDR_W-1:0]  bases [4];
    bit [ADDR_W-1:0]  addr;
    bit [BYTES_W-1:0] len;
    bit               calm;
    int               pick, pages;
    bases = '{24'h000000, 24'h5A5000, 24'hA5A000, 24'hFA0000};
    foreach (page_refs[i]) page_refs[i] = '0;

    // Directed: zero length, first regions, run breaks, underflow, full span,
    // rejection, the top page.
    queue_request(1'b0, 24'h000000, 19'd0, 1'b0, 1'b0);
    queue_request(1'b1, 24'hFFFFFF, 19'd0, 1'b0, 1'b0);
    queue_request(1'b0, 24'h000000, 19'd1, 1'b0, 1'b0);
    queue_request(1'b0, 24'h000000, 19'h3000, 1'b0, 1'b0);     // page 0 breaks the run
    queue_request(1'b1, 24'h000800, 19'h2000, 1'b0, 1'b0);
    queue_request(1'b1, 24'h005000, 19'd1, 1'b0, 1'b0);        // underflow alone
    queue_request(1'b1, 24'h000000, 19'h6000, 1'b0, 1'b0);     // underflow closes a run
    queue_request(1'b0, 24'h100000, 19'(MAX_LEN), 1'b0, 1'b0); // widest span
    queue_request(1'b0, 24'h100001, 19'(MAX_LEN), 1'b0, 1'b0); // one page too many
    queue_request(1'b1, 24'h100000, 19'(MAX_LEN), 1'b0, 1'b0);
    queue_request(1'b0, 24'hFFF000, 19'h1000, 1'b0, 1'b0);
    queue_request(1'b0, 24'hFFFFFF, 19'd2, 1'b0, 1'b0);        // runs past the table
    queue_request(1'b1, 24'hFFFFFF, 19'd1, 1'b0, 1'b1);
    queue_request(1'b0, 24'h200000, 19'h1000, 1'b0, 1'b0);
    queue_request(1'b0, 24'h202000, 19'h1000, 1'b0, 1'b0);
    queue_request(1'b0, 24'h205000, 19'h1000, 1'b0, 1'b0);
    queue_request(1'b0, 24'h200000, 19'h8000, 1'b0, 1'b0);     // regions split by live pages
    queue_request(1'b1, 24'h200000, 19'h8000, 1'b0, 1'b0);

    // Overlapping ranges around one page, then drain.
    queue_request(1'b0, 24'h300000, 19'd1, 1'b0, 1'b0);
    queue_request(1'b0, 24'h2FF000, 19'h3000, 1'b0, 1'b0);
    queue_request(1'b0, 24'h300FFF, 19'd1, 1'b0, 1'b0);
    queue_request(1'b1, 24'h300000, 19'd1, 1'b0, 1'b1);

    // Random: mostly short ranges in a few windows so counts rise and fall,
    // with some wild addresses, zero lengths and rejected ranges.
    for (int i = 0; i < 80; i++) begin
      calm = ((i / 20) % 3) == 1;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        addr = ADDR_W'($urandom);
        len  = BYTES_W'($urandom_range(0, MAX_LEN));
      end else if (pick == 1) begin
        if ($urandom_range(0, 1)) begin
          addr = ADDR_W'($urandom);
          len  = '0;
        end else begin
          addr = 24'hFFF000 | ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
          len  = BYTES_W'($urandom_range(PAGE_BYTES + 1, MAX_LEN));
        end
      end else begin
        pages = ($urandom_range(0, 4) == 0) ? $urandom_range(17, MAX_REQ_PAGES)
                                            : $urandom_range(1, 16);
        addr  = bases[$urandom_range(0, 3)] + ADDR_W'($urandom_range(0, 95) << PAGE_BITS);
        if ($urandom_range(0, 1)) addr = addr + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
        len = BYTES_W'(pages * PAGE_BYTES);
        if ($urandom_range(0, 1)) len = len - BYTES_W'($urandom_range(0, PAGE_BYTES - 1));
      end
      queue_request(1'($urandom_range(0, 1)), addr, len, calm, i == 50);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() > 0 || have_req || regions_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/prt_pkg.sv
rtl/core/prt_ram.sv
rtl/core/prt_fifo.sv
rtl/core/prt_front.sv
rtl/core/prt_back.sv
rtl/core/page_refcount_region_tracker_top.sv
tb/sv/page_refcount_region_tracker_top_test.sv
